### hw/rtl/windowed_peak_rms_meter_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the windowed peak and RMS meter
// Shorthand for clocked assertions that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_PEAK_RMS_METER_MACROS_SVH
`define WINDOWED_PEAK_RMS_METER_MACROS_SVH

// Check cons in the same cycle whenever ante holds
`define WPRM_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante holds
`define WPRM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/wprm_pkg.sv
// ----------------------------------------------------------------------------
// Windowed peak and RMS meter package
// Payload types, sequencer states, control groups and shared constants.
// ----------------------------------------------------------------------------
package wprm_pkg;

   // Fixed sample width of the payload (signed Q1.15)
   localparam int SAMPLE_BITS    = 16;
   // Default width of the bucket counter and the bucket size register
   localparam int COUNT_BITS_DEF = 16;
   // Configuration port geometry
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;

   // Register index, taken from the word address bit
   typedef enum logic {
      REG_FRAMES_PER_BUCKET = 1'b0
   } reg_index_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          clip_end;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] peak;
      logic [SAMPLE_BITS-1:0] rms;
      logic                   last_bucket;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ACCUM,
      ST_DIVIDE,
      ST_ROOT,
      ST_EMIT
   } state_type;

   // Strobes from the sequencer to the datapath
   typedef struct packed {
      logic take_sample;
      logic square;
      logic accum;
      logic div_step;
      logic div_last;
      logic root_step;
      logic emit;
   } ctrl_type;

   // Conditions from the datapath to the sequencer
   typedef struct packed {
      logic close;
      logic out_free;
   } status_type;

endpackage

### hw/rtl/wprm_sub_unit.sv
// ----------------------------------------------------------------------------
// Shared compare and subtract unit
// One subtractor serving both the long division and the square root steps.
// ----------------------------------------------------------------------------
module wprm_sub_unit #(
   parameter int WIDTH = 25
) (
   input  logic [WIDTH-1:0] op_a,
   input  logic [WIDTH-1:0] op_b,
   output logic [WIDTH-1:0] diff,
   output logic             ge
);

   logic [WIDTH:0] wide_diff;

   // Subtract with one guard bit; no borrow means a >= b
   assign wide_diff = {1'b0, op_a} - {1'b0, op_b};
   assign diff      = wide_diff[WIDTH-1:0];
   assign ge        = ~wide_diff[WIDTH];

endmodule

### hw/rtl/wprm_ctrl.sv
// ----------------------------------------------------------------------------
// Meter sequencer
// Steps one request through square and accumulate, and on a bucket close through divide, root and emit.
// ----------------------------------------------------------------------------
module wprm_ctrl
   import wprm_pkg::*;
#(
   parameter int WORK_BITS = 46,
   parameter int ROOT_BITS = 23
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  status_type status,
   output logic       req_ready,
   output ctrl_type   ctrl_out
);

   localparam int STEP_BITS = $clog2(WORK_BITS);

   state_type             state_ff, state_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  div_done;
   logic                  root_done;

   assign div_done  = (step_ff == STEP_BITS'(WORK_BITS - 1));
   assign root_done = (step_ff == STEP_BITS'(ROOT_BITS - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            state_in = status.close ? ST_DIVIDE : ST_IDLE;
         end
         ST_DIVIDE: begin
            if (div_done) state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Step counter: advance inside divide and root, restart on each phase change
   always_comb begin
      step_in = '0;
      if ((state_ff == ST_DIVIDE && !div_done) || (state_ff == ST_ROOT && !root_done)) begin
         step_in = step_ff + STEP_BITS'(1);
      end
   end

   // Outputs
   always_comb begin
      req_ready = 1'b0;
      ctrl_out  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready            = 1'b1;
            ctrl_out.take_sample = req_valid;
         end
         ST_SQUARE: begin
            ctrl_out.square = 1'b1;
         end
         ST_ACCUM: begin
            ctrl_out.accum = 1'b1;
         end
         ST_DIVIDE: begin
            ctrl_out.div_step = 1'b1;
            ctrl_out.div_last = div_done;
         end
         ST_ROOT: begin
            ctrl_out.root_step = 1'b1;
         end
         ST_EMIT: begin
            ctrl_out.emit = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

### hw/rtl/windowed_peak_rms_meter.sv
// ----------------------------------------------------------------------------
// Windowed peak and RMS level meter
// Groups signed Q1.15 samples into buckets and reports peak magnitude and
// floor RMS for each bucket, through one shared subtractor.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid/req_ready    req_type: sample, clip_end
//   rsp      out        rsp_valid/rsp_ready    rsp_type: peak, rms, last_bucket
//   csr      in/out     APB, pready tied high  frames_per_bucket at address 0
//
// A request that leaves its bucket open passes through accept, square and
// accumulate. A request that closes a bucket adds a restoring division of
// WORK_BITS steps and a square root of ROOT_BITS steps on the shared
// subtractor, and then loads the output register. Reset is synchronous and
// clears the bucket state; the bucket size resets to 1. A stalled response
// holds in the output register while the next request is taken in; the
// sequencer waits only when a new result is ready and the previous one is
// still not taken.
// ----------------------------------------------------------------------------
module windowed_peak_rms_meter
   import wprm_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data,
   // configuration port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int SUM_RAW   = 2 * SAMPLE_BITS - 2 + COUNT_BITS;
   localparam int SUM_BITS  = (SUM_RAW > 64) ? 64 : SUM_RAW;
   localparam int SQ_BITS   = 2 * SAMPLE_BITS - 1;
   localparam int ROOT_BITS = (SUM_BITS + 1) / 2;
   localparam int WORK_BITS = 2 * ROOT_BITS;
   localparam int UNIT_BITS = ROOT_BITS + 2;

   ctrl_type   ctrl;
   status_type status;

   logic [COUNT_BITS-1:0]  fpb_ff, fpb_in;
   logic [SAMPLE_BITS-1:0] mag_ff, mag_in;
   logic                   last_ff, last_in;
   logic [SQ_BITS-1:0]     sq_ff, sq_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0] peak_ff, peak_in;
   logic [COUNT_BITS-1:0]  fill_ff, fill_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [WORK_BITS-1:0]   work_ff, work_in;
   logic [UNIT_BITS-1:0]   rem_ff, rem_in;
   logic [ROOT_BITS-1:0]   root_ff, root_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic                        csr_write;
   logic [2*SAMPLE_BITS-1:0]    product;
   logic [SUM_BITS:0]           sum_wide;
   logic [SUM_BITS-1:0]         sum_next;
   logic [COUNT_BITS-1:0]       count_next;
   logic [SAMPLE_BITS-1:0]      req_mag;
   logic [UNIT_BITS-1:0]        unit_a, unit_b, unit_diff;
   logic                        unit_ge;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_FRAMES_PER_BUCKET) ?
                       CSR_DATA_BITS'(fpb_ff) : '0;

   always_comb begin
      fpb_in = fpb_ff;
      if (csr_write && csr_paddr[2] == REG_FRAMES_PER_BUCKET) begin
         fpb_in = csr_pwdata[COUNT_BITS-1:0];
      end
   end

   // Sequencer
   assign status.close    = last_ff | (count_next >= fpb_ff);
   assign status.out_free = ~rsp_valid_ff | rsp_ready;

   wprm_ctrl #(
      .WORK_BITS (WORK_BITS),
      .ROOT_BITS (ROOT_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .req_ready (req_ready),
      .ctrl_out  (ctrl)
   );

   // Magnitude of the incoming sample; the most negative code maps to 2^15
   assign req_mag = req_data.sample[SAMPLE_BITS-1] ?
                    (~req_data.sample + SAMPLE_BITS'(1)) : req_data.sample;

   // Square and saturating accumulate
   assign product    = {{SAMPLE_BITS{1'b0}}, mag_ff} * {{SAMPLE_BITS{1'b0}}, mag_ff};
   assign sum_wide   = {1'b0, sum_ff} + (SUM_BITS+1)'(sq_ff);
   assign sum_next   = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
   assign count_next = fill_ff + COUNT_BITS'(1);

   // Operand select for the shared subtractor
   always_comb begin
      if (ctrl.root_step) begin
         unit_a = {rem_ff[UNIT_BITS-3:0], work_ff[WORK_BITS-1 -: 2]};
         unit_b = {root_ff, 2'b01};
      end else begin
         unit_a = {rem_ff[UNIT_BITS-2:0], work_ff[WORK_BITS-1]};
         unit_b = UNIT_BITS'(count_ff);
      end
   end

   wprm_sub_unit #(
      .WIDTH (UNIT_BITS)
   ) u_sub (
      .op_a (unit_a),
      .op_b (unit_b),
      .diff (unit_diff),
      .ge   (unit_ge)
   );

   // Datapath next values
   always_comb begin
      mag_in   = mag_ff;
      last_in  = last_ff;
      sq_in    = sq_ff;
      sum_in   = sum_ff;
      peak_in  = peak_ff;
      fill_in  = fill_ff;
      count_in = count_ff;
      work_in  = work_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;

      // capture the request
      if (ctrl.take_sample) begin
         mag_in  = req_mag;
         last_in = req_data.clip_end;
      end

      if (ctrl.square) begin
         sq_in = product[SQ_BITS-1:0];
      end

      // fold into the bucket; on close hand the sum to the divider
      if (ctrl.accum) begin
         peak_in = (mag_ff > peak_ff) ? mag_ff : peak_ff;
         if (status.close) begin
            fill_in  = '0;
            sum_in   = '0;
            work_in  = WORK_BITS'(sum_next);
            count_in = count_next;
            rem_in   = '0;
         end else begin
            fill_in = count_next;
            sum_in  = sum_next;
         end
      end

      // one quotient bit per step, quotient shifts into the work register
      if (ctrl.div_step) begin
         rem_in  = unit_ge ? unit_diff : unit_a;
         work_in = {work_ff[WORK_BITS-2:0], unit_ge};
         if (ctrl.div_last) begin
            rem_in  = '0;
            root_in = '0;
         end
      end

      // one root bit per step, two radicand bits consumed
      if (ctrl.root_step) begin
         rem_in  = unit_ge ? unit_diff : unit_a;
         root_in = {root_ff[ROOT_BITS-2:0], unit_ge};
         work_in = {work_ff[WORK_BITS-3:0], 2'b00};
      end

      if (ctrl.emit) begin
         peak_in = '0;
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (ctrl.emit) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.peak        = peak_ff;
         rsp_data_in.rms         = root_ff[SAMPLE_BITS-1:0];
         rsp_data_in.last_bucket = last_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Control and bucket state
   always_ff @(posedge clock) begin
      if (reset) begin
         fpb_ff       <= COUNT_BITS'(1);
         fill_ff      <= '0;
         peak_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fpb_ff       <= fpb_in;
         fill_ff      <= fill_in;
         peak_ff      <= peak_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      last_ff     <= last_in;
      sq_ff       <= sq_in;
      count_ff    <= count_in;
      work_ff     <= work_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### hw/rtl/wprm_checker.sv
// ----------------------------------------------------------------------------
// Windowed peak and RMS meter port checker
// Watches the top level ports for sequencing and register slips.
// ----------------------------------------------------------------------------
`include "windowed_peak_rms_meter_macros.svh"

module wprm_checker
   import wprm_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input rsp_type                  rsp_data,
   input logic                     csr_psel,
   input logic                     csr_penable,
   input logic                     csr_pwrite,
   input logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input logic [CSR_DATA_BITS-1:0] csr_pwdata,
   input logic [CSR_DATA_BITS-1:0] csr_prdata,
   input logic                     csr_pready
);

   // The sequencer is busy in the cycle after each request
   `WPRM_ASSERT_NEXT(a_busy_after_request, req_valid && req_ready, !req_ready, "ready after request")

   // A new response never appears right after a request was taken
   `WPRM_ASSERT_SAME(a_no_instant_response, $rose(rsp_valid), !$past(req_valid && req_ready), "response too early")

   // A stalled response holds its payload
   `WPRM_ASSERT_NEXT(a_stall_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled response changed")

   // A bucket size write reads back truncated to the counter width
   `WPRM_ASSERT_NEXT(a_size_readback, csr_psel && csr_penable && csr_pwrite && csr_pready && (csr_paddr[2] == REG_FRAMES_PER_BUCKET), (csr_paddr[2] != REG_FRAMES_PER_BUCKET) || (csr_prdata == CSR_DATA_BITS'($past(csr_pwdata[COUNT_BITS-1:0]))), "bucket size readback")

endmodule

bind windowed_peak_rms_meter wprm_checker #(.COUNT_BITS(COUNT_BITS)) u_checker (.*);
